### hdl/eda_pkg.sv
// Package with types, constants and helper functions for the Elephant Delirium AEAD block.
package eda_pkg;

    // Geometry of the permutation state and the nonce.
    localparam int BLK         = 25;
    localparam int NONCE_BYTES = 12;
    localparam int MAX_ROUNDS  = 18;

    // Input opcodes.
    localparam logic [1:0] OP_AD_BYTE  = 2'd0;
    localparam logic [1:0] OP_AD_END   = 2'd1;
    localparam logic [1:0] OP_MSG_BYTE = 2'd2;
    localparam logic [1:0] OP_FINISH   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY_LOW    = 3'd0;
    localparam logic [2:0] REG_KEY_HIGH   = 3'd1;
    localparam logic [2:0] REG_NONCE_LOW  = 3'd2;
    localparam logic [2:0] REG_NONCE_HIGH = 3'd3;
    localparam logic [2:0] REG_ENC_MODE   = 3'd4;

    typedef logic [BLK*8-1:0] state_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_kind;
        logic       last;
    } out_item_t;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_PERM,
        ST_DISPATCH,
        ST_ABS_PERM,
        ST_AFTER_ABS,
        ST_KS_PERM,
        ST_MSG_OUT,
        ST_TAG_OUT
    } seq_state_t;

    // Why an absorb was started, which decides what follows it.
    typedef enum logic [1:0] {
        AB_AD_FULL,
        AB_AD_END,
        AB_MSG_FULL,
        AB_FINISH
    } abs_kind_t;

    typedef logic [7:0] rc_table_t [MAX_ROUNDS];
    localparam rc_table_t ROUND_CONST = '{
        8'h01, 8'h82, 8'h8a, 8'h00, 8'h8b, 8'h01, 8'h81, 8'h09, 8'h8a,
        8'h88, 8'h09, 8'h0a, 8'h8b, 8'h8b, 8'h89, 8'h03, 8'h02, 8'h80
    };

    typedef logic [2:0] rho_table_t [BLK];
    localparam rho_table_t RHO_OFF = '{
        3'd0, 3'd1, 3'd6, 3'd4, 3'd3, 3'd4, 3'd4, 3'd6, 3'd7, 3'd4, 3'd3, 3'd2, 3'd3,
        3'd1, 3'd7, 3'd1, 3'd5, 3'd7, 3'd5, 3'd0, 3'd2, 3'd2, 3'd5, 3'd0, 3'd6
    };

    // Rotate a byte left by a small amount.
    function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] r);
        logic [15:0] w;
        begin
            w = {v, v} << r;
            rotl8 = w[15:8];
        end
    endfunction

    // One LFSR step of the mask chain: shift down one byte, new byte on top.
    function automatic state_t mask_next(input state_t s);
        logic [7:0] fb;
        begin
            fb = rotl8(s[7:0], 3'd1) ^ rotl8(s[23:16], 3'd1) ^ {s[110:104], 1'b0};
            mask_next = {fb, s[BLK*8-1:8]};
        end
    endfunction

endpackage

### hdl/elephant_delirium_aead.sv
// Top level of the Elephant v2 Delirium AEAD engine with its sequencer.
// Elephant v2 Delirium AEAD, one request byte at a time. Every permutation runs on one
// shared Keccak-f[200] round engine at one round per cycle. A byte that completes a
// 25-byte block, an end of associated data and a finish each absorb that block with a
// permutation. A message byte that starts a block first computes its keystream with a
// permutation. The first request of a session first expands the key with a permutation.
// A finish request absorbs the last block and then delivers TAG_BYTES tag bytes, at
// most one per cycle. A message or tag byte waits while the previous output byte has
// not been taken. The block accepts no request while busy.
module elephant_delirium_aead #(
    parameter int ROUNDS    = 18,
    parameter int TAG_BYTES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  eda_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output eda_pkg::out_item_t  out_data
);

    localparam int SB = eda_pkg::BLK * 8;

    // Configuration registers.
    logic [63:0] key_low_reg, key_high_reg, nonce_low_reg;
    logic [31:0] nonce_high_reg;
    logic        enc_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            enc_mode_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                eda_pkg::REG_KEY_LOW:    key_low_reg    <= cfg_data;
                eda_pkg::REG_KEY_HIGH:   key_high_reg   <= cfg_data;
                eda_pkg::REG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                eda_pkg::REG_NONCE_HIGH: nonce_high_reg <= cfg_data[31:0];
                eda_pkg::REG_ENC_MODE:   enc_mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [SB-1:0] nonce_blk;
    assign nonce_blk = {{(SB-96){1'b0}}, nonce_high_reg, nonce_low_reg};

    // Sequencer and datapath registers.
    eda_pkg::seq_state_t state_reg, state_next;
    eda_pkg::abs_kind_t  akind_reg, akind_next;
    logic                sess_reg, sess_next;
    logic                phase_reg, phase_next;
    logic [4:0]          pos_reg, pos_next;
    logic [4:0]          tcnt_reg, tcnt_next;
    eda_pkg::in_item_t   item_reg, item_next;
    logic [SB-1:0]       am0_reg, am0_next, am1_reg, am1_next, am2_reg, am2_next;
    logic [SB-1:0]       mm0_reg, mm0_next, mm1_reg, mm1_next;
    logic [SB-1:0]       buf_reg, buf_next, ks_reg, ks_next;
    logic [SB-1:0]       mab_reg, mab_next;
    logic [127:0]        tag_reg, tag_next;
    logic [7:0]          obyte_reg, obyte_next;
    logic                okind_reg, okind_next, olast_reg, olast_next;
    logic                ovalid_reg, ovalid_next;

    logic                perm_start, perm_done;
    eda_pkg::state_t     perm_din, perm_dout;

    eda_round #(.ROUNDS(ROUNDS)) u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .start (perm_start),
        .din   (perm_din),
        .done  (perm_done),
        .dout  (perm_dout)
    );

    // Next state and datapath control.
    always_comb
    begin
        logic [SB-1:0] e1, e2, bufw, tmp;
        logic [7:0]    r;
        logic [4:0]    p;
        state_next  = state_reg;
        akind_next  = akind_reg;
        sess_next   = sess_reg;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        tcnt_next   = tcnt_reg;
        item_next   = item_reg;
        am0_next    = am0_reg;
        am1_next    = am1_reg;
        am2_next    = am2_reg;
        mm0_next    = mm0_reg;
        mm1_next    = mm1_reg;
        buf_next    = buf_reg;
        ks_next     = ks_reg;
        mab_next    = mab_reg;
        tag_next    = tag_reg;
        obyte_next  = obyte_reg;
        okind_next  = okind_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg;
        perm_start  = 1'b0;
        perm_din    = buf_reg ^ mab_reg;
        in_ready    = 1'b0;
        e1          = '0;
        e2          = '0;
        bufw        = buf_reg;
        tmp         = '0;
        r           = '0;
        p           = (pos_reg >= 5'd25) ? 5'd0 : pos_reg;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            eda_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next = in_data;
                    if (!sess_reg)
                    begin
                        perm_start = 1'b1;
                        perm_din   = {{(SB-128){1'b0}}, key_high_reg, key_low_reg};
                        state_next = eda_pkg::ST_KEY_PERM;
                    end
                    else
                    begin
                        state_next = eda_pkg::ST_DISPATCH;
                    end
                end
            end

            eda_pkg::ST_KEY_PERM:
            begin
                if (perm_done)
                begin
                    e1         = eda_pkg::mask_next(perm_dout);
                    e2         = eda_pkg::mask_next(e1);
                    am0_next   = perm_dout;
                    am1_next   = e1;
                    am2_next   = e2;
                    mm0_next   = perm_dout;
                    mm1_next   = e1;
                    buf_next   = nonce_blk;
                    pos_next   = 5'(eda_pkg::NONCE_BYTES);
                    tag_next   = '0;
                    phase_next = 1'b0;
                    sess_next  = 1'b1;
                    state_next = eda_pkg::ST_DISPATCH;
                end
            end

            eda_pkg::ST_DISPATCH:
            begin
                pos_next = p;
                if (item_reg.opcode == eda_pkg::OP_AD_BYTE
                    || item_reg.opcode == eda_pkg::OP_AD_END)
                begin
                    if (phase_reg)
                    begin
                        state_next = eda_pkg::ST_IDLE;
                    end
                    else if (item_reg.opcode == eda_pkg::OP_AD_END)
                    begin
                        bufw             = buf_reg;
                        bufw[8*p +: 8]   = 8'h01;
                        mab_next         = am0_reg ^ am2_reg;
                        perm_start       = 1'b1;
                        perm_din         = bufw ^ am0_reg ^ am2_reg;
                        akind_next       = eda_pkg::AB_AD_END;
                        state_next       = eda_pkg::ST_ABS_PERM;
                    end
                    else
                    begin
                        bufw           = buf_reg;
                        bufw[8*p +: 8] = item_reg.data_byte;
                        buf_next       = bufw;
                        pos_next       = p + 5'd1;
                        if (p == 5'd24)
                        begin
                            mab_next   = am0_reg ^ am2_reg;
                            perm_start = 1'b1;
                            perm_din   = bufw ^ am0_reg ^ am2_reg;
                            akind_next = eda_pkg::AB_AD_FULL;
                            state_next = eda_pkg::ST_ABS_PERM;
                        end
                        else
                        begin
                            state_next = eda_pkg::ST_IDLE;
                        end
                    end
                end
                else if (!phase_reg)
                begin
                    // Message or finish during associated data: close it first.
                    bufw           = buf_reg;
                    bufw[8*p +: 8] = 8'h01;
                    mab_next       = am0_reg ^ am2_reg;
                    perm_start     = 1'b1;
                    perm_din       = bufw ^ am0_reg ^ am2_reg;
                    akind_next     = eda_pkg::AB_AD_END;
                    state_next     = eda_pkg::ST_ABS_PERM;
                end
                else if (item_reg.opcode == eda_pkg::OP_MSG_BYTE)
                begin
                    if (p == 5'd0)
                    begin
                        perm_start = 1'b1;
                        perm_din   = nonce_blk ^ mm0_reg;
                        state_next = eda_pkg::ST_KS_PERM;
                    end
                    else
                    begin
                        state_next = eda_pkg::ST_MSG_OUT;
                    end
                end
                else
                begin
                    bufw           = buf_reg;
                    bufw[8*p +: 8] = 8'h01;
                    mab_next       = mm0_reg ^ mm1_reg;
                    perm_start     = 1'b1;
                    perm_din       = bufw ^ mm0_reg ^ mm1_reg;
                    akind_next     = eda_pkg::AB_FINISH;
                    state_next     = eda_pkg::ST_ABS_PERM;
                end
            end

            eda_pkg::ST_ABS_PERM:
            begin
                if (perm_done)
                begin
                    tmp        = perm_dout ^ mab_reg;
                    tag_next   = tag_reg ^ tmp[127:0];
                    buf_next   = '0;
                    pos_next   = 5'd0;
                    state_next = eda_pkg::ST_AFTER_ABS;
                end
            end

            eda_pkg::ST_AFTER_ABS:
            begin
                unique case (akind_reg)
                    eda_pkg::AB_AD_FULL:
                    begin
                        am0_next   = am1_reg;
                        am1_next   = am2_reg;
                        am2_next   = eda_pkg::mask_next(am2_reg);
                        state_next = eda_pkg::ST_IDLE;
                    end
                    eda_pkg::AB_AD_END:
                    begin
                        phase_next = 1'b1;
                        if (item_reg.opcode == eda_pkg::OP_AD_END)
                        begin
                            state_next = eda_pkg::ST_IDLE;
                        end
                        else
                        begin
                            state_next = eda_pkg::ST_DISPATCH;
                        end
                    end
                    eda_pkg::AB_MSG_FULL:
                    begin
                        mm0_next   = mm1_reg;
                        mm1_next   = eda_pkg::mask_next(mm1_reg);
                        state_next = eda_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        tcnt_next  = '0;
                        sess_next  = 1'b0;
                        state_next = eda_pkg::ST_TAG_OUT;
                    end
                endcase
            end

            eda_pkg::ST_KS_PERM:
            begin
                if (perm_done)
                begin
                    ks_next    = perm_dout ^ mm0_reg;
                    state_next = eda_pkg::ST_MSG_OUT;
                end
            end

            eda_pkg::ST_MSG_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    r              = item_reg.data_byte ^ ks_reg[8*p +: 8];
                    bufw           = buf_reg;
                    bufw[8*p +: 8] = enc_mode_reg ? r : item_reg.data_byte;
                    buf_next       = bufw;
                    pos_next       = p + 5'd1;
                    obyte_next     = r;
                    okind_next     = 1'b0;
                    olast_next     = 1'b0;
                    ovalid_next    = 1'b1;
                    if (p == 5'd24)
                    begin
                        mab_next   = mm0_reg ^ mm1_reg;
                        perm_start = 1'b1;
                        perm_din   = bufw ^ mm0_reg ^ mm1_reg;
                        akind_next = eda_pkg::AB_MSG_FULL;
                        state_next = eda_pkg::ST_ABS_PERM;
                    end
                    else
                    begin
                        state_next = eda_pkg::ST_IDLE;
                    end
                end
            end

            eda_pkg::ST_TAG_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    obyte_next  = tag_reg[8*tcnt_reg[3:0] +: 8];
                    okind_next  = 1'b1;
                    olast_next  = (tcnt_reg == 5'(TAG_BYTES - 1));
                    ovalid_next = 1'b1;
                    tcnt_next   = tcnt_reg + 5'd1;
                    if (tcnt_reg == 5'(TAG_BYTES - 1))
                    begin
                        buf_next   = nonce_blk;
                        pos_next   = 5'(eda_pkg::NONCE_BYTES);
                        phase_next = 1'b0;
                        state_next = eda_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = eda_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= eda_pkg::ST_IDLE;
            sess_reg   <= 1'b0;
            phase_reg  <= 1'b0;
            pos_reg    <= 5'(eda_pkg::NONCE_BYTES);
            tcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
            akind_reg  <= eda_pkg::AB_AD_FULL;
        end
        else
        begin
            state_reg  <= state_next;
            sess_reg   <= sess_next;
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            tcnt_reg   <= tcnt_next;
            ovalid_reg <= ovalid_next;
            akind_reg  <= akind_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        am0_reg   <= am0_next;
        am1_reg   <= am1_next;
        am2_reg   <= am2_next;
        mm0_reg   <= mm0_next;
        mm1_reg   <= mm1_next;
        buf_reg   <= buf_next;
        ks_reg    <= ks_next;
        mab_reg   <= mab_next;
        tag_reg   <= tag_next;
        obyte_reg <= obyte_next;
        okind_reg <= okind_next;
        olast_reg <= olast_next;
    end

    assign out_valid         = ovalid_reg;
    assign out_data.out_byte = obyte_reg;
    assign out_data.out_kind = okind_reg;
    assign out_data.last     = olast_reg;

endmodule

### hdl/eda_round.sv
// One Keccak-f[200] round engine, iterated over the permutation's rounds.
module eda_round #(
    parameter int ROUNDS = 18
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  eda_pkg::state_t din,
    output logic            done,
    output eda_pkg::state_t dout
);

    localparam int RW = $clog2(eda_pkg::MAX_ROUNDS + 1);

    eda_pkg::state_t s_reg, s_next;
    logic [RW-1:0]   rnd_reg, rnd_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    // Combinational round: theta, rho, pi, chi, iota.
    always_comb
    begin
        logic [7:0] c [5];
        logic [7:0] d [5];
        logic [7:0] a [25];
        logic [7:0] t [25];
        for (int x = 0; x < 5; x++)
        begin
            c[x] = s_reg[8*x +: 8] ^ s_reg[8*(x+5) +: 8] ^ s_reg[8*(x+10) +: 8]
                 ^ s_reg[8*(x+15) +: 8] ^ s_reg[8*(x+20) +: 8];
        end
        for (int x = 0; x < 5; x++)
        begin
            d[x] = eda_pkg::rotl8(c[(x+1)%5], 3'd1) ^ c[(x+4)%5];
        end
        for (int i = 0; i < 25; i++)
        begin
            a[i] = eda_pkg::rotl8(s_reg[8*i +: 8] ^ d[i%5], eda_pkg::RHO_OFF[i]);
        end
        for (int x = 0; x < 5; x++)
        begin
            for (int y = 0; y < 5; y++)
            begin
                t[y + 5*((2*x + 3*y) % 5)] = a[x + 5*y];
            end
        end
        s_next = s_reg;
        for (int y = 0; y < 5; y++)
        begin
            for (int x = 0; x < 5; x++)
            begin
                s_next[8*(x+5*y) +: 8] = t[x+5*y] ^ (~t[(x+1)%5 + 5*y] & t[(x+2)%5 + 5*y]);
            end
        end
        s_next[7:0] = s_next[7:0] ^ eda_pkg::ROUND_CONST[rnd_reg[4:0]];

        rnd_next  = rnd_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            s_next    = din;
            rnd_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rnd_next = rnd_reg + RW'(1);
            if (rnd_reg == RW'(ROUNDS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else
        begin
            s_next = s_reg;
        end
    end

    // State and round counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rnd_reg  <= rnd_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
    end

    assign done = done_reg;
    assign dout = s_reg;

endmodule

### tb/elephant_delirium_aead_checker.sv
// Checker for the Elephant Delirium AEAD engine: predicts output bytes and compares them.
`timescale 1ns / 100ps
module elephant_delirium_aead_checker #(
    parameter int ROUNDS    = 18,
    parameter int TAG_BYTES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  eda_pkg::in_item_t   in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  eda_pkg::out_item_t  out_data,
    output int                  fail_count,
    output int                  pending_count
);

    typedef logic [7:0] blk_t [eda_pkg::BLK];

    // Shadow copies of the configuration registers.
    logic [63:0] key_lo_q, key_hi_q, nonce_lo_q;
    logic [31:0] nonce_hi_q;
    logic        encrypt_q;

    // Predicted engine state.
    blk_t        ad_mask [3];
    blk_t        msg_mask [2];
    blk_t        buffer_q;
    blk_t        stream_q;
    logic [7:0]  tag_acc [16];
    int          pos_q;
    logic        in_msg_q;
    logic        session_q;

    eda_pkg::out_item_t expected_bytes [$];

    assign pending_count = expected_bytes.size();

    function automatic logic [7:0] rot_left(input logic [7:0] v, input int r);
        logic [15:0] w;
        begin
            w = {v, v} << (r % 8);
            return w[15:8];
        end
    endfunction

    // Keccak-f[200] permutation over the configured number of rounds.
    function automatic blk_t permute(input blk_t s);
        logic [7:0] c [5];
        logic [7:0] d [5];
        logic [7:0] t [eda_pkg::BLK];
        logic [7:0] row [5];
        begin
            for (int r = 0; r < ROUNDS && r < 18; r++)
            begin
                for (int x = 0; x < 5; x++)
                    c[x] = s[x] ^ s[x+5] ^ s[x+10] ^ s[x+15] ^ s[x+20];
                for (int x = 0; x < 5; x++)
                    d[x] = rot_left(c[(x+1)%5], 1) ^ c[(x+4)%5];
                for (int x = 0; x < eda_pkg::BLK; x++)
                    s[x] = rot_left(s[x] ^ d[x%5], int'(eda_pkg::RHO_OFF[x]));
                for (int x = 0; x < 5; x++)
                    for (int y = 0; y < 5; y++)
                        t[y + 5*((2*x + 3*y) % 5)] = s[x + 5*y];
                for (int y = 0; y < 5; y++)
                begin
                    for (int x = 0; x < 5; x++)
                        row[x] = t[x+5*y] ^ (~t[(x+1)%5 + 5*y] & t[(x+2)%5 + 5*y]);
                    for (int x = 0; x < 5; x++)
                        s[x+5*y] = row[x];
                end
                s[0] = s[0] ^ eda_pkg::ROUND_CONST[r];
            end
            return s;
        end
    endfunction

    // Next mask of the LFSR chain.
    function automatic blk_t step_mask(input blk_t m);
        blk_t n;
        begin
            for (int i = 0; i < eda_pkg::BLK-1; i++)
                n[i] = m[i+1];
            n[eda_pkg::BLK-1] = rot_left(m[0], 1) ^ rot_left(m[2], 1) ^ {m[13][6:0], 1'b0};
            return n;
        end
    endfunction

    function automatic blk_t nonce_block();
        blk_t b;
        begin
            for (int i = 0; i < eda_pkg::BLK; i++)
                b[i] = 8'h00;
            for (int i = 0; i < 8; i++)
                b[i] = nonce_lo_q[8*i +: 8];
            for (int i = 0; i < 4; i++)
                b[8+i] = nonce_hi_q[8*i +: 8];
            return b;
        end
    endfunction

    // Mask, permute, mask and fold the buffered block into the tag.
    task automatic absorb(input blk_t ma, input blk_t mb);
        blk_t t;
        begin
            for (int i = 0; i < eda_pkg::BLK; i++)
                t[i] = buffer_q[i] ^ ma[i] ^ mb[i];
            t = permute(t);
            for (int i = 0; i < TAG_BYTES && i < 16; i++)
                tag_acc[i] = tag_acc[i] ^ t[i] ^ ma[i] ^ mb[i];
            for (int i = 0; i < eda_pkg::BLK; i++)
                buffer_q[i] = 8'h00;
            pos_q = 0;
        end
    endtask

    task automatic open_session();
        blk_t ek;
        begin
            for (int i = 0; i < eda_pkg::BLK; i++)
                ek[i] = 8'h00;
            for (int i = 0; i < 8; i++)
            begin
                ek[i]   = key_lo_q[8*i +: 8];
                ek[8+i] = key_hi_q[8*i +: 8];
            end
            ek = permute(ek);
            ad_mask[0] = ek;
            ad_mask[1] = step_mask(ek);
            ad_mask[2] = step_mask(ad_mask[1]);
            msg_mask[0] = ad_mask[0];
            msg_mask[1] = ad_mask[1];
            buffer_q = nonce_block();
            pos_q = eda_pkg::NONCE_BYTES;
            for (int i = 0; i < 16; i++)
                tag_acc[i] = 8'h00;
            in_msg_q = 1'b0;
            session_q = 1'b1;
        end
    endtask

    task automatic finish_assoc();
        begin
            if (pos_q >= eda_pkg::BLK)
                pos_q = 0;
            buffer_q[pos_q] = 8'h01;
            absorb(ad_mask[0], ad_mask[2]);
            in_msg_q = 1'b1;
        end
    endtask

    // Advance the prediction by one accepted request.
    task automatic predict_request(input eda_pkg::in_item_t req);
        logic [7:0]         r;
        eda_pkg::out_item_t o;
        begin
            if (!session_q)
                open_session();
            if (pos_q >= eda_pkg::BLK)
                pos_q = 0;
            if (req.opcode == eda_pkg::OP_AD_BYTE || req.opcode == eda_pkg::OP_AD_END)
            begin
                if (!in_msg_q)
                begin
                    if (req.opcode == eda_pkg::OP_AD_END)
                        finish_assoc();
                    else
                    begin
                        buffer_q[pos_q] = req.data_byte;
                        pos_q++;
                        if (pos_q == eda_pkg::BLK)
                        begin
                            absorb(ad_mask[0], ad_mask[2]);
                            ad_mask[0] = ad_mask[1];
                            ad_mask[1] = ad_mask[2];
                            ad_mask[2] = step_mask(ad_mask[1]);
                        end
                    end
                end
            end
            else
            begin
                if (!in_msg_q)
                    finish_assoc();
                if (req.opcode == eda_pkg::OP_MSG_BYTE)
                begin
                    if (pos_q == 0)
                    begin
                        stream_q = nonce_block();
                        for (int i = 0; i < eda_pkg::BLK; i++)
                            stream_q[i] = stream_q[i] ^ msg_mask[0][i];
                        stream_q = permute(stream_q);
                        for (int i = 0; i < eda_pkg::BLK; i++)
                            stream_q[i] = stream_q[i] ^ msg_mask[0][i];
                    end
                    r = req.data_byte ^ stream_q[pos_q];
                    buffer_q[pos_q] = encrypt_q ? r : req.data_byte;
                    pos_q++;
                    if (pos_q == eda_pkg::BLK)
                    begin
                        absorb(msg_mask[0], msg_mask[1]);
                        msg_mask[0] = msg_mask[1];
                        msg_mask[1] = step_mask(msg_mask[0]);
                    end
                    o.out_byte = r;
                    o.out_kind = 1'b0;
                    o.last     = 1'b0;
                    expected_bytes.push_back(o);
                end
                else
                begin
                    buffer_q[pos_q] = 8'h01;
                    absorb(msg_mask[0], msg_mask[1]);
                    for (int i = 0; i < TAG_BYTES && i < 16; i++)
                    begin
                        o.out_byte = tag_acc[i];
                        o.out_kind = 1'b1;
                        o.last     = (i + 1 == TAG_BYTES);
                        expected_bytes.push_back(o);
                    end
                    session_q = 1'b0;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        begin
            $display("%0t: mismatch: %s", $time, what);
            fail_count++;
        end
    endtask

    // Watch configuration writes, requests and output bytes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_q   <= '0;
            key_hi_q   <= '0;
            nonce_lo_q <= '0;
            nonce_hi_q <= '0;
            encrypt_q  <= 1'b1;
            session_q  = 1'b0;
            in_msg_q   = 1'b0;
            pos_q      = eda_pkg::NONCE_BYTES;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    eda_pkg::REG_KEY_LOW:    key_lo_q   <= cfg_data;
                    eda_pkg::REG_KEY_HIGH:   key_hi_q   <= cfg_data;
                    eda_pkg::REG_NONCE_LOW:  nonce_lo_q <= cfg_data;
                    eda_pkg::REG_NONCE_HIGH: nonce_hi_q <= cfg_data[31:0];
                    eda_pkg::REG_ENC_MODE:   encrypt_q  <= cfg_data[0];
                    default:                 ;
                endcase
            end
            if (in_valid && in_ready)
                predict_request(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch($sformatf("unexpected output %h", out_data));
                else
                begin
                    eda_pkg::out_item_t e;
                    e = expected_bytes.pop_front();
                    if (out_data.out_byte !== e.out_byte)
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  out_data.out_byte, e.out_byte));
                    if (out_data.out_kind !== e.out_kind)
                        report_mismatch($sformatf("out_kind %b, expected %b",
                                                  out_data.out_kind, e.out_kind));
                    if (out_data.last !== e.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  out_data.last, e.last));
                end
            end
        end
    end

endmodule

### tb/elephant_delirium_aead_test.sv
// Testbench top for the Elephant Delirium AEAD engine: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module elephant_delirium_aead_test;

    localparam int STALL_LIMIT = 20000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = eda_pkg::REG_KEY_LOW;
    logic [63:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    eda_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    eda_pkg::out_item_t out_data;
    int                 fail_count;
    int                 pending_count;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 quiet_cycles = 0;
    int                 requests_sent = 0;

    elephant_delirium_aead u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    elephant_delirium_aead_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    // Receiver backpressure.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one request and hold it until the engine takes it. Valid stays high after
    // acceptance so that a following request can replace it in the same cycle.
    task automatic send_request(input logic [1:0] op, input logic [7:0] b);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= '{opcode: op, data_byte: b};
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            requests_sent++;
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
        end
    endtask

    // Wait for every predicted byte and let the engine settle.
    task automatic drain();
        begin
            in_valid <= 1'b0;
            while (pending_count != 0)
                @(posedge clk);
            repeat (200) @(posedge clk);
        end
    endtask

    task automatic load_config(input logic [63:0] kl, input logic [63:0] kh,
                               input logic [63:0] nl, input logic [31:0] nh,
                               input logic enc);
        begin
            write_reg(eda_pkg::REG_KEY_LOW, kl);
            write_reg(eda_pkg::REG_KEY_HIGH, kh);
            write_reg(eda_pkg::REG_NONCE_LOW, nl);
            write_reg(eda_pkg::REG_NONCE_HIGH, {32'h0, nh});
            write_reg(eda_pkg::REG_ENC_MODE, {63'h0, enc});
            cfg_we <= 1'b0;
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // A well formed session with random lengths, sometimes malformed.
    task automatic random_session();
        int ad_len, msg_len;
        begin
            ad_len  = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(16);
            msg_len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(20);
            for (int i = 0; i < ad_len; i++)
                send_request(eda_pkg::OP_AD_BYTE, 8'($urandom_range(255)));
            if ($urandom_range(3) != 0)
                send_request(eda_pkg::OP_AD_END, 8'($urandom_range(255)));
            for (int i = 0; i < msg_len; i++)
            begin
                // Occasional stray requests that the message phase ignores.
                if ($urandom_range(15) == 0)
                    send_request(2'($urandom_range(1)), 8'($urandom_range(255)));
                send_request(eda_pkg::OP_MSG_BYTE, 8'($urandom_range(255)));
            end
            send_request(eda_pkg::OP_FINISH, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default registers, empty session.
        send_request(eda_pkg::OP_FINISH, 8'h00);
        drain();
        load_config('1, '1, '1, 32'hffff_ffff, 1'b1);
        send_request(eda_pkg::OP_AD_BYTE, 8'hff);
        send_request(eda_pkg::OP_AD_BYTE, 8'h00);
        send_request(eda_pkg::OP_AD_END, 8'h5a);
        send_request(eda_pkg::OP_AD_BYTE, 8'h11);
        send_request(eda_pkg::OP_MSG_BYTE, 8'h00);
        send_request(eda_pkg::OP_MSG_BYTE, 8'hff);
        send_request(eda_pkg::OP_AD_END, 8'h00);
        send_request(eda_pkg::OP_FINISH, 8'hff);
        // Message byte straight after open, then finish during AD.
        send_request(eda_pkg::OP_MSG_BYTE, 8'ha5);
        send_request(eda_pkg::OP_FINISH, 8'h00);
        send_request(eda_pkg::OP_AD_BYTE, 8'h3c);
        send_request(eda_pkg::OP_FINISH, 8'h00);
        drain();
        load_config('0, 64'h0123_4567_89ab_cdef, '0, 32'h0, 1'b0);
        // Thirteen AD bytes fill the first block exactly.
        for (int i = 0; i < 13; i++)
            send_request(eda_pkg::OP_AD_BYTE, 8'(i));
        send_request(eda_pkg::OP_MSG_BYTE, 8'h80);
        send_request(eda_pkg::OP_FINISH, 8'h00);
        drain();

        // Random sessions under three idling regimes.
        for (int phase_sel = 0; phase_sel < 3; phase_sel++)
        begin
            send_idle_pct = (phase_sel == 0) ? 24 : (phase_sel == 1) ? 86 : 0;
            recv_idle_pct = (phase_sel == 0) ? 86 : (phase_sel == 1) ? 24 : 0;
            load_config(rand64(), rand64(), rand64(), $urandom, 1'($urandom_range(1)));
            while (requests_sent < 135 * (phase_sel + 1))
            begin
                random_session();
                if ($urandom_range(2) == 0)
                begin
                    drain();
                    load_config(rand64(), rand64(), rand64(), $urandom,
                                1'($urandom_range(1)));
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### elephant_delirium_aead.f
hdl/eda_pkg.sv
hdl/eda_round.sv
hdl/elephant_delirium_aead.sv
tb/elephant_delirium_aead_checker.sv
tb/elephant_delirium_aead_test.sv
